// File: hw/rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and codes for the mesh route candidate compute unit.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int COORD_W = 4;
    localparam int ALG_W   = 3;
    localparam int DIR_W   = 3;
    localparam int CNT_W   = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 4;

    localparam logic [DIR_W-1:0] DIR_N = 3'd0;
    localparam logic [DIR_W-1:0] DIR_E = 3'd1;
    localparam logic [DIR_W-1:0] DIR_S = 3'd2;
    localparam logic [DIR_W-1:0] DIR_W_ = 3'd3;
    localparam logic [DIR_W-1:0] DIR_L = 3'd4;

    localparam logic [ALG_W-1:0] ALG_XY        = 3'd0;
    localparam logic [ALG_W-1:0] ALG_WEST_1ST  = 3'd1;
    localparam logic [ALG_W-1:0] ALG_NORTH_LST = 3'd2;
    localparam logic [ALG_W-1:0] ALG_NEG_1ST   = 3'd3;
    localparam logic [ALG_W-1:0] ALG_ODD_EVEN  = 3'd4;
    localparam logic [ALG_W-1:0] ALG_DYAD      = 3'd5;
    localparam logic [ALG_W-1:0] ALG_FULL_ADPT = 3'd6;

    localparam logic [CIDX_W-1:0] REG_ALGORITHM = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ROUTER_X  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_ROUTER_Y  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic [ALG_W-1:0]   algorithm;
        logic [COORD_W-1:0] router_x;
        logic [COORD_W-1:0] router_y;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
        logic               congested;
    } req_t;

    typedef struct packed {
        logic [DIR_W-1:0] first_dir;
        logic [DIR_W-1:0] second_dir;
        logic [CNT_W-1:0] dir_count;
    } cand_t;

endpackage

// File: hw/rtl/mrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrc_cfg_regs
// Configuration register file: algorithm select and router coordinates.
// ----------------------------------------------------------------------------
module mrc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mrc_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [mrc_pkg::CDATA_W-1:0] cfg_data,
    output mrc_pkg::cfg_t               cfg
);
    import mrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ALGORITHM: cfg_next.algorithm = cfg_data[ALG_W-1:0];
                REG_ROUTER_X:  cfg_next.router_x  = cfg_data[COORD_W-1:0];
                REG_ROUTER_Y:  cfg_next.router_y  = cfg_data[COORD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/mrc_route.sv
// ----------------------------------------------------------------------------
// mrc_route
// Turn-model route candidate logic for one registered head flit.
// ----------------------------------------------------------------------------
module mrc_route (
    input  mrc_pkg::cfg_t  cfg,
    input  mrc_pkg::req_t  req,
    output mrc_pkg::cand_t cand
);
    import mrc_pkg::*;

    logic             x_gt;
    logic             x_lt;
    logic             x_eq;
    logic             y_gt;
    logic             y_lt;
    logic             y_eq;
    logic [DIR_W-1:0] xy_dir;
    logic [COORD_W:0] cx_plus1;
    logic             oe_take_v;
    logic             oe_take_e;
    cand_t            oe;

    assign x_gt = req.dst_x > cfg.router_x;
    assign x_lt = req.dst_x < cfg.router_x;
    assign x_eq = !x_gt && !x_lt;
    assign y_gt = req.dst_y > cfg.router_y;
    assign y_lt = req.dst_y < cfg.router_y;
    assign y_eq = !y_gt && !y_lt;

    assign xy_dir   = x_gt ? DIR_E : (x_lt ? DIR_W_ : (y_gt ? DIR_S : DIR_N));
    assign cx_plus1 = {1'b0, cfg.router_x} + {{COORD_W{1'b0}}, 1'b1};

    // odd-even turn model
    assign oe_take_v = cfg.router_x[0] || (cfg.router_x == req.src_x);
    assign oe_take_e = req.dst_x[0] || ({1'b0, req.dst_x} != cx_plus1);

    always_comb
    begin
        oe = '{first_dir: DIR_N, second_dir: DIR_N, dir_count: CNT_NONE};
        if (x_eq)
        begin
            oe.first_dir = y_lt ? DIR_N : DIR_S;
            oe.dir_count = CNT_ONE;
        end
        else if (x_gt)
        begin
            if (y_eq)
            begin
                oe.first_dir = DIR_E;
                oe.dir_count = CNT_ONE;
            end
            else if (oe_take_v)
            begin
                oe.first_dir = y_lt ? DIR_N : DIR_S;
                if (oe_take_e)
                begin
                    oe.second_dir = DIR_E;
                    oe.dir_count  = CNT_TWO;
                end
                else
                begin
                    oe.dir_count = CNT_ONE;
                end
            end
            else if (oe_take_e)
            begin
                oe.first_dir = DIR_E;
                oe.dir_count = CNT_ONE;
            end
        end
        else
        begin
            oe.first_dir = DIR_W_;
            oe.dir_count = CNT_ONE;
            if (!cfg.router_x[0] && !y_eq)
            begin
                oe.second_dir = y_lt ? DIR_N : DIR_S;
                oe.dir_count  = CNT_TWO;
            end
        end
    end

    always_comb
    begin
        cand = '{first_dir: xy_dir, second_dir: DIR_N, dir_count: CNT_ONE};
        if (x_eq && y_eq)
        begin
            cand.first_dir = DIR_L;
        end
        else
        begin
            unique case (cfg.algorithm)
                ALG_WEST_1ST:
                begin
                    if (x_gt && !y_eq)
                    begin
                        cand = '{first_dir: y_lt ? DIR_N : DIR_S,
                                 second_dir: DIR_E, dir_count: CNT_TWO};
                    end
                end
                ALG_NORTH_LST:
                begin
                    if (!x_eq && y_gt)
                    begin
                        cand = '{first_dir: DIR_S, second_dir: x_lt ? DIR_W_ : DIR_E,
                                 dir_count: CNT_TWO};
                    end
                end
                ALG_NEG_1ST:
                begin
                    if (x_gt && y_lt)
                    begin
                        cand = '{first_dir: DIR_N, second_dir: DIR_E, dir_count: CNT_TWO};
                    end
                    else if (x_lt && y_gt)
                    begin
                        cand = '{first_dir: DIR_S, second_dir: DIR_W_, dir_count: CNT_TWO};
                    end
                end
                ALG_ODD_EVEN:
                begin
                    cand = oe;
                end
                ALG_DYAD:
                begin
                    cand = oe;
                    if (!req.congested && (oe.dir_count == CNT_TWO))
                    begin
                        cand.dir_count  = CNT_ONE;
                        cand.second_dir = DIR_N;
                    end
                end
                ALG_FULL_ADPT:
                begin
                    if (!x_eq && !y_eq)
                    begin
                        cand = '{first_dir: y_lt ? DIR_N : DIR_S,
                                 second_dir: x_gt ? DIR_E : DIR_W_, dir_count: CNT_TWO};
                    end
                end
                default:
                begin
                    cand.first_dir = xy_dir;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mesh_route_candidate_compute_unit.sv
// ----------------------------------------------------------------------------
// mesh_route_candidate_compute_unit
// Route computation for one router of a 2D mesh network on chip.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present src_x, dst_x, dst_y and congested with start high; the
//   transaction is taken at the clock edge where start is high and busy low.
//   busy is always low, so a head flit may be issued in every cycle.
//   Output: result_valid pulses for one cycle with first_dir, second_dir and
//   dir_count. An accepted transaction is held in the input register, then
//   passes through the route logic into the result register. Throughput is
//   one transaction per cycle, set by the single registered pass through
//   the route logic.
//   The receiver cannot stall; each result is held for exactly one cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 algorithm,
//   1 router_x, 2 router_y) and cfg_data; cfg_ready is always high. Write
//   only while no transaction is in flight.
//   Reset clears the configuration registers (algorithm XY, router at 0,0) and the
//   pipeline valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mesh_route_candidate_compute_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mrc_pkg::COORD_W-1:0] src_x,
    input  logic [mrc_pkg::COORD_W-1:0] dst_x,
    input  logic [mrc_pkg::COORD_W-1:0] dst_y,
    input  logic                        congested,
    output logic                        result_valid,
    output logic [mrc_pkg::DIR_W-1:0]   first_dir,
    output logic [mrc_pkg::DIR_W-1:0]   second_dir,
    output logic [mrc_pkg::CNT_W-1:0]   dir_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mrc_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [mrc_pkg::CDATA_W-1:0] cfg_data
);
    import mrc_pkg::*;

    cfg_t  cfg;
    req_t  req_reg;
    logic  in_valid_reg;
    cand_t cand_next;
    cand_t cand_reg;
    logic  out_valid_reg;

    assign busy = 1'b0;

    mrc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= '{src_x: src_x, dst_x: dst_x, dst_y: dst_y, congested: congested};
        end
        if (in_valid_reg)
        begin
            cand_reg <= cand_next;
        end
    end

    mrc_route u_route (
        .cfg  (cfg),
        .req  (req_reg),
        .cand (cand_next)
    );

    assign result_valid = out_valid_reg;
    assign first_dir    = cand_reg.first_dir;
    assign second_dir   = cand_reg.second_dir;
    assign dir_count    = cand_reg.dir_count;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 result_valid)
        else $error("accepted transaction did not produce a result");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(in_valid_reg))
        else $error("result without an accepted transaction");

    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (dir_count != CNT_TWO)) |-> (second_dir == DIR_N))
        else $error("second direction set with fewer than two candidates");

    a_local_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (first_dir == DIR_L)) |-> (dir_count == CNT_ONE))
        else $error("local route with more than one candidate");
`endif

endmodule

// File: test/mrc_route_checker.sv
// ----------------------------------------------------------------------------
// mrc_route_checker
// Watches the request, result and register write channels of the mesh route
// candidate compute unit. Keeps its own copy of the routing registers,
// predicts the candidate directions for every accepted request, and compares
// each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mrc_route_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [mrc_pkg::COORD_W-1:0] src_x,
    input  logic [mrc_pkg::COORD_W-1:0] dst_x,
    input  logic [mrc_pkg::COORD_W-1:0] dst_y,
    input  logic                        congested,
    input  logic                        result_valid,
    input  logic [mrc_pkg::DIR_W-1:0]   first_dir,
    input  logic [mrc_pkg::DIR_W-1:0]   second_dir,
    input  logic [mrc_pkg::CNT_W-1:0]   dir_count,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [mrc_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [mrc_pkg::CDATA_W-1:0] cfg_data,
    output int                          fail_count,
    output int                          pending
);

    import mrc_pkg::*;

    cand_t expected_routes [$];
    cfg_t  route_cfg;
    int    mismatches = 0;

    function automatic logic [DIR_W-1:0] xy_step(int cx, int cy, int dx, int dy);
        if (dx > cx)
            return DIR_E;
        else if (dx < cx)
            return DIR_W_;
        else if (dy > cy)
            return DIR_S;
        else
            return DIR_N;
    endfunction

    function automatic cand_t predict_route(req_t rq, cfg_t cf);
        int               cx;
        int               cy;
        int               sx;
        int               dx;
        int               dy;
        int               e0;
        int               e1;
        int               n;
        logic [DIR_W-1:0] d [2];
        cand_t            res;
        cx   = int'(cf.router_x);
        cy   = int'(cf.router_y);
        sx   = int'(rq.src_x);
        dx   = int'(rq.dst_x);
        dy   = int'(rq.dst_y);
        e0   = dx - cx;
        e1   = cy - dy;
        n    = 1;
        d[0] = xy_step(cx, cy, dx, dy);
        d[1] = DIR_N;
        if (dx == cx && dy == cy)
        begin
            d[0] = DIR_L;
        end
        else
        begin
            case (cf.algorithm)
                ALG_WEST_1ST:
                    if (!(dx <= cx || dy == cy))
                    begin
                        d[0] = (dy < cy) ? DIR_N : DIR_S;
                        d[1] = DIR_E;
                        n    = 2;
                    end
                ALG_NORTH_LST:
                    if (!(dx == cx || dy <= cy))
                    begin
                        d[0] = DIR_S;
                        d[1] = (dx < cx) ? DIR_W_ : DIR_E;
                        n    = 2;
                    end
                ALG_NEG_1ST:
                    if (dx > cx && dy < cy)
                    begin
                        d[0] = DIR_N;
                        d[1] = DIR_E;
                        n    = 2;
                    end
                    else if (dx < cx && dy > cy)
                    begin
                        d[0] = DIR_S;
                        d[1] = DIR_W_;
                        n    = 2;
                    end
                ALG_ODD_EVEN, ALG_DYAD:
                begin
                    if (e0 == 0)
                    begin
                        d[0] = (e1 > 0) ? DIR_N : DIR_S;
                    end
                    else if (e0 > 0)
                    begin
                        d[0] = DIR_E;
                        if (e1 != 0)
                        begin
                            n = 0;
                            if (cx % 2 == 1 || cx == sx)
                            begin
                                d[n] = (e1 > 0) ? DIR_N : DIR_S;
                                n++;
                            end
                            if (dx % 2 == 1 || e0 != 1)
                            begin
                                d[n] = DIR_E;
                                n++;
                            end
                        end
                    end
                    else
                    begin
                        d[0] = DIR_W_;
                        if (cx % 2 == 0 && e1 != 0)
                        begin
                            d[1] = (e1 > 0) ? DIR_N : DIR_S;
                            n    = 2;
                        end
                    end
                    if (cf.algorithm == ALG_DYAD && !rq.congested && n > 1)
                        n = 1;
                end
                ALG_FULL_ADPT:
                    if (!(dx == cx || dy == cy))
                    begin
                        d[0] = (dy < cy) ? DIR_N : DIR_S;
                        d[1] = (dx > cx) ? DIR_E : DIR_W_;
                        n    = 2;
                    end
                default:
                    ;
            endcase
        end
        res.first_dir  = (n == 0) ? DIR_N : d[0];
        res.second_dir = (n == 2) ? d[1] : '0;
        res.dir_count  = (n == 2) ? CNT_TWO : (n == 1) ? CNT_ONE : CNT_NONE;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        req_t  rq;
        cand_t want;
        cand_t got;
        if (!rst_n)
        begin
            route_cfg.algorithm = ALG_XY;
            route_cfg.router_x  = '0;
            route_cfg.router_y  = '0;
            expected_routes.delete();
        end
        else
        begin
            if (start && !busy)
            begin
                rq.src_x     = src_x;
                rq.dst_x     = dst_x;
                rq.dst_y     = dst_y;
                rq.congested = congested;
                expected_routes.insert(expected_routes.size(),
                                       predict_route(rq, route_cfg));
            end
            if (result_valid)
            begin
                got.first_dir  = first_dir;
                got.second_dir = second_dir;
                got.dir_count  = dir_count;
                if (expected_routes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected route: first %0d second %0d count %0d",
                                 got.first_dir, got.second_dir, got.dir_count);
                end
                else
                begin
                    want = expected_routes.pop_front();
                    if (got.first_dir !== want.first_dir
                        || got.second_dir !== want.second_dir
                        || got.dir_count !== want.dir_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("route mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.first_dir, want.second_dir, want.dir_count,
                                     got.first_dir, got.second_dir, got.dir_count);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ALGORITHM: route_cfg.algorithm = cfg_data[ALG_W-1:0];
                    REG_ROUTER_X:  route_cfg.router_x  = cfg_data[COORD_W-1:0];
                    REG_ROUTER_Y:  route_cfg.router_y  = cfg_data[COORD_W-1:0];
                    default:       ;
                endcase
            end
        end
        fail_count <= mismatches;
        pending    <= expected_routes.size();
    end

endmodule

// File: test/mesh_route_candidate_compute_unit_tb.sv
// ----------------------------------------------------------------------------
// mesh_route_candidate_compute_unit_tb
// Drives head flit routing requests into the route candidate compute unit.
// A directed pass covers local delivery, every algorithm and the odd-even
// column rules; random phases then sweep all algorithm codes and router
// positions, corners included, with random idle gaps and pipeline drains.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module mesh_route_candidate_compute_unit_tb;

    import mrc_pkg::*;

    localparam int                PHASES          = 24;
    localparam int                ITEMS_PER_PHASE = 64;
    localparam int                STALL_LIMIT     = 1000;
    localparam int                SETTLE_CYCLES   = 4;
    localparam logic [CIDX_W-1:0] REG_SPARE       = 2'd3;
    localparam logic [ALG_W-1:0]  ALG_XY_ALIAS    = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [COORD_W-1:0]  src_x;
    logic [COORD_W-1:0]  dst_x;
    logic [COORD_W-1:0]  dst_y;
    logic                congested;
    logic                result_valid;
    logic [DIR_W-1:0]    first_dir;
    logic [DIR_W-1:0]    second_dir;
    logic [CNT_W-1:0]    dir_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CDATA_W-1:0]  cfg_data;

    int                  fail_count;
    int                  pending;
    int                  stall_cycles = 0;
    logic [ALG_W-1:0]    cur_alg;
    logic [COORD_W-1:0]  cur_rx;
    logic [COORD_W-1:0]  cur_ry;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    mesh_route_candidate_compute_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .src_x        (src_x),
        .dst_x        (dst_x),
        .dst_y        (dst_y),
        .congested    (congested),
        .result_valid (result_valid),
        .first_dir    (first_dir),
        .second_dir   (second_dir),
        .dir_count    (dir_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mrc_route_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .src_x        (src_x),
        .dst_x        (dst_x),
        .dst_y        (dst_y),
        .congested    (congested),
        .result_valid (result_valid),
        .first_dir    (first_dir),
        .second_dir   (second_dir),
        .dir_count    (dir_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int idle_gap(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 14);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    function automatic req_t random_route_req();
        req_t rq;
        rq.src_x     = ($urandom_range(0, 3) == 0) ? cur_rx : COORD_W'($urandom_range(0, 15));
        rq.dst_x     = COORD_W'($urandom_range(0, 15));
        rq.dst_y     = COORD_W'($urandom_range(0, 15));
        rq.congested = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:
            begin
                rq.dst_x = cur_rx;
                rq.dst_y = cur_ry;
            end
            1:       rq.dst_x = cur_rx + 4'd1;
            2:       rq.dst_x = cur_rx;
            3:       rq.dst_y = cur_ry;
            default: ;
        endcase
        return rq;
    endfunction

    task automatic send_route(req_t rq, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        src_x     <= rq.src_x;
        dst_x     <= rq.dst_x;
        dst_y     <= rq.dst_y;
        congested <= rq.congested;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_routes();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(logic [CDATA_W-1:0] alg_data, logic [COORD_W-1:0] rx,
                             logic [COORD_W-1:0] ry);
        drain_routes();
        write_reg(REG_ALGORITHM, alg_data);
        write_reg(REG_ROUTER_X, rx);
        write_reg(REG_ROUTER_Y, ry);
        write_reg(REG_SPARE, CDATA_W'($urandom_range(0, 15)));
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_alg = alg_data[ALG_W-1:0];
        cur_rx  = rx;
        cur_ry  = ry;
    endtask

    task automatic directed_route(logic [CDATA_W-1:0] alg_data, logic [COORD_W-1:0] rx,
                                  logic [COORD_W-1:0] ry, logic [COORD_W-1:0] sx,
                                  logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy,
                                  logic cong);
        req_t rq;
        if (alg_data[ALG_W-1:0] != cur_alg || rx != cur_rx || ry != cur_ry)
            configure(alg_data, rx, ry);
        rq.src_x     = sx;
        rq.dst_x     = dx;
        rq.dst_y     = dy;
        rq.congested = cong;
        send_route(rq, 0);
    endtask

    initial
    begin
        logic [ALG_W-1:0]   alg;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        int                 mode;
        rst_n     = 1'b0;
        start     = 1'b0;
        src_x     = '0;
        dst_x     = '0;
        dst_y     = '0;
        congested = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ALGORITHM;
        cfg_data  = '0;
        cur_alg   = ALG_XY;
        cur_rx    = '0;
        cur_ry    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: XY at the origin
        directed_route({1'b0, ALG_XY}, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
        directed_route({1'b0, ALG_XY}, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15, 1'b1);
        directed_route({1'b0, ALG_XY}, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0, 1'b0);
        directed_route({1'b0, ALG_XY}, 4'd15, 4'd15, 4'd0, 4'd15, 4'd0, 1'b0);
        directed_route({1'b0, ALG_WEST_1ST}, 4'd8, 4'd8, 4'd0, 4'd12, 4'd3, 1'b0);
        directed_route({1'b0, ALG_WEST_1ST}, 4'd8, 4'd8, 4'd0, 4'd3, 4'd12, 1'b0);
        directed_route({1'b0, ALG_NORTH_LST}, 4'd8, 4'd8, 4'd0, 4'd3, 4'd12, 1'b0);
        directed_route({1'b0, ALG_NORTH_LST}, 4'd8, 4'd8, 4'd0, 4'd8, 4'd2, 1'b0);
        directed_route({1'b0, ALG_NEG_1ST}, 4'd8, 4'd8, 4'd0, 4'd12, 4'd3, 1'b0);
        directed_route({1'b0, ALG_NEG_1ST}, 4'd8, 4'd8, 4'd0, 4'd3, 4'd12, 1'b0);
        directed_route({1'b0, ALG_NEG_1ST}, 4'd8, 4'd8, 4'd0, 4'd3, 4'd3, 1'b0);
        // odd column
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd7, 4'd8, 4'd0, 4'd12, 4'd3, 1'b0);
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd7, 4'd8, 4'd0, 4'd8, 4'd12, 1'b0);
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd7, 4'd8, 4'd0, 4'd7, 4'd3, 1'b0);
        // even column, source column rule and westward turns
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd6, 4'd8, 4'd6, 4'd7, 4'd12, 1'b0);
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd6, 4'd8, 4'd0, 4'd9, 4'd3, 1'b0);
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd6, 4'd8, 4'd0, 4'd2, 4'd3, 1'b0);
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd6, 4'd8, 4'd0, 4'd2, 4'd8, 1'b0);
        directed_route({1'b0, ALG_ODD_EVEN}, 4'd6, 4'd8, 4'd3, 4'd6, 4'd8, 1'b1);
        directed_route({1'b0, ALG_DYAD}, 4'd6, 4'd8, 4'd0, 4'd2, 4'd3, 1'b0);
        directed_route({1'b0, ALG_DYAD}, 4'd6, 4'd8, 4'd0, 4'd2, 4'd3, 1'b1);
        directed_route({1'b0, ALG_FULL_ADPT}, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 1'b0);
        directed_route({1'b0, ALG_FULL_ADPT}, 4'd0, 4'd15, 4'd0, 4'd0, 4'd0, 1'b0);
        directed_route({1'b1, ALG_XY_ALIAS}, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            alg = ALG_W'(p % 8);
            if (p < 8)
            begin
                rx = (p % 2 == 1) ? 4'hF : 4'h0;
                ry = ((p / 2) % 2 == 1) ? 4'hF : 4'h0;
            end
            else
            begin
                rx = COORD_W'($urandom_range(0, 15));
                ry = COORD_W'($urandom_range(0, 15));
            end
            configure({1'($urandom_range(0, 1)), alg}, rx, ry);
            mode = 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i % 16 == 0)
                    mode = $urandom_range(0, 2);
                if ($urandom_range(0, 39) == 0)
                    drain_routes();
                send_route(random_route_req(), idle_gap(mode));
            end
        end

        drain_routes();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_cfg_regs.sv
hw/rtl/mrc_route.sv
hw/rtl/mesh_route_candidate_compute_unit.sv
test/mrc_route_checker.sv
test/mesh_route_candidate_compute_unit_tb.sv
